FILE: hw/rtl/crs_pkg.sv
// crs_pkg: shared types, constants and small lookup functions for the
// character display refresh sequencer. No dependencies.
package crs_pkg;

	localparam int DISPLAY_CHARS = 80;
	localparam int LINE_CHARS    = 20;
	localparam int ADDR_W        = 7;
	localparam int INIT_LEN      = 5;
	localparam int STEP_W        = 3;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_IDX_W     = 1;

	localparam logic [7:0] SHORT_RELOAD_RST = 8'd243;
	localparam logic [7:0] LONG_RELOAD_RST  = 8'd48;

	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_FUNC_SET = 8'h38;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_LINE0    = 8'h80;
	localparam logic [7:0] CMD_LINE1    = 8'hC0;
	localparam logic [7:0] CMD_LINE2    = 8'h94;
	localparam logic [7:0] CMD_LINE3    = 8'hD4;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_RELOAD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_RELOAD  = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_INIT  = 2'd2,
		OP_CMD   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_CMD  = 4'b0010,
		MODE_DATA = 4'b0100,
		MODE_INIT = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] char_address;
		logic [7:0] char_code;
		logic [7:0] command_byte;
	} item_t;

	typedef struct packed {
		logic       write_valid;
		logic       register_select;
		logic [7:0] bus_data;
		logic [7:0] timer_reload;
	} result_t;

	// classified item as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic             store_we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]       payload;
	} entry_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] cmd;
	} line_cmd_t;

	function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step);
		logic [7:0] c;
		unique case (step)
			STEP_W'(0): c = CMD_FUNC_SET;
			STEP_W'(1): c = CMD_DISP_ON;
			STEP_W'(2): c = CMD_CLEAR;
			STEP_W'(3): c = CMD_LINE0;
			STEP_W'(4): c = CMD_HOME;
			default:    c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic line_cmd_t line_cmd(input logic [ADDR_W-1:0] pos);
		line_cmd_t r;
		r.hit = 1'b1;
		unique case (pos)
			ADDR_W'(0):            r.cmd = CMD_LINE0;
			ADDR_W'(LINE_CHARS):   r.cmd = CMD_LINE1;
			ADDR_W'(2*LINE_CHARS): r.cmd = CMD_LINE2;
			ADDR_W'(3*LINE_CHARS): r.cmd = CMD_LINE3;
			default: begin
				r.hit = 1'b0;
				r.cmd = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/crs_front.sv
// crs_front: accepts items, classifies them and holds them in a short queue
// for the back end. Depends on crs_pkg.
module crs_front #(
	parameter int DEPTH = crs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  crs_pkg::item_t  item,
	output logic            head_valid,
	output crs_pkg::entry_t head,
	input  logic            pop
);
	import crs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             q_mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	entry_t             cls;
	logic               push;
	logic               do_pop;

	// classify: resolve the opcode, range-check the store address, pick the byte
	always_comb begin
		cls.op       = op_t'(item.opcode);
		cls.store_we = (cls.op == OP_WRITE) && (item.char_address < ADDR_W'(DISPLAY_CHARS));
		cls.addr     = item.char_address;
		cls.payload  = (cls.op == OP_WRITE) ? item.char_code : item.command_byte;
	end

	assign item_ready = (count_q != CNT_W'(DEPTH));
	assign push       = item_valid && item_ready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/crs_back.sv
// crs_back: executes queued items in order: owns the frame store, the
// sequencer state, the reload registers and the result register. Depends on crs_pkg.
module crs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  crs_pkg::cfg_wr_t cfg,
	input  logic             head_valid,
	input  crs_pkg::entry_t  head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output crs_pkg::result_t result
);
	import crs_pkg::*;

	logic [7:0]        char_mem [DISPLAY_CHARS];
	logic [DISPLAY_CHARS-1:0] written_q;

	logic [7:0]        short_q;
	logic [7:0]        long_q;
	mode_t             mode_q, mode_d;
	logic [ADDR_W-1:0] pos_q, pos_d, pos_nxt;
	logic [7:0]        pend_q, pend_d;
	logic [STEP_W-1:0] step_q, step_d;
	line_cmd_t         lc;

	logic              is_tick;
	logic              mem_we;
	logic              rd_en;
	logic              wv_d, rs_d, store_d;
	logic [7:0]        byte_d, reload_d;

	logic              valid_s2, wv_s2, rs_s2, store_s2, hit_s2;
	logic [7:0]        byte_s2, reload_s2, rdata_s2;

	assign pop     = head_valid && (!valid_s2 || result_ready);
	assign pos_nxt = (pos_q < ADDR_W'(DISPLAY_CHARS - 1)) ? pos_q + ADDR_W'(1) : '0;
	assign lc      = line_cmd(pos_nxt);

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		pend_d   = pend_q;
		step_d   = step_q;
		is_tick  = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		wv_d     = 1'b0;
		rs_d     = 1'b0;
		store_d  = 1'b0;
		byte_d   = 8'h00;
		reload_d = 8'h00;
		if (pop) begin
			unique case (head.op)
				OP_WRITE: mem_we = head.store_we;
				OP_INIT: begin
					step_d = '0;
					mode_d = MODE_INIT;
				end
				OP_CMD: begin
					pend_d = head.payload;
					mode_d = MODE_CMD;
				end
				OP_TICK: begin
					is_tick = 1'b1;
					unique case (mode_q)
						MODE_DATA: begin
							wv_d     = 1'b1;
							rs_d     = 1'b1;
							store_d  = (pos_q < ADDR_W'(DISPLAY_CHARS));
							rd_en    = store_d;
							reload_d = short_q;
							pos_d    = pos_nxt;
							// line start: set-address goes out on the next tick
							if (lc.hit) begin
								pend_d = lc.cmd;
								mode_d = MODE_CMD;
							end
						end
						MODE_CMD: begin
							wv_d     = 1'b1;
							byte_d   = pend_q;
							reload_d = (pend_q == CMD_CLEAR) ? long_q : short_q;
							mode_d   = MODE_DATA;
						end
						MODE_INIT: begin
							if (step_q < STEP_W'(INIT_LEN)) begin
								wv_d     = 1'b1;
								byte_d   = init_cmd(step_q);
								reload_d = (byte_d == CMD_CLEAR) ? long_q : short_q;
								step_d   = step_q + STEP_W'(1);
							end else begin
								reload_d = short_q;
								mode_d   = MODE_DATA;
								step_d   = '0;
								pos_d    = '0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			char_mem[head.addr] <= head.payload;
		end
		if (rd_en) begin
			rdata_s2 <= char_mem[pos_q];
		end
		if (pop) begin
			wv_s2     <= wv_d;
			rs_s2     <= rs_d;
			store_s2  <= store_d;
			byte_s2   <= byte_d;
			reload_s2 <= reload_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_s2    <= 1'b0;
			short_q   <= SHORT_RELOAD_RST;
			long_q    <= LONG_RELOAD_RST;
			mode_q    <= MODE_IDLE;
			pos_q     <= '0;
			pend_q    <= '0;
			step_q    <= '0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == CFG_SHORT_RELOAD) begin
				short_q <= cfg.data;
			end
			if (cfg.we && cfg.index == CFG_LONG_RELOAD) begin
				long_q <= cfg.data;
			end
			if (mem_we) begin
				written_q[head.addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_s2 <= written_q[pos_q];
			end
			mode_q <= mode_d;
			pos_q  <= pos_d;
			pend_q <= pend_d;
			step_q <= step_d;
			if (pop) begin
				valid_s2 <= is_tick;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// a never-written cell reads as zero
	assign result_valid           = valid_s2;
	assign result.write_valid     = wv_s2;
	assign result.register_select = rs_s2;
	assign result.bus_data        = store_s2 ? (hit_s2 ? rdata_s2 : 8'h00) : byte_s2;
	assign result.timer_reload    = reload_s2;

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !wv_s2 |-> !rs_s2 && !store_s2 && byte_s2 == 8'h00)
		else $error("tick without bus write carries bus fields");
	a_store_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && store_s2 |-> wv_s2 && rs_s2)
		else $error("frame store byte sent on command register");
	// read data of a never-written cell is don't-care, only the flag must hold
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_ready |=> $stable(hit_s2) && (!hit_s2 || $stable(rdata_s2)))
		else $error("store read data changed under a stalled result");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < ADDR_W'(DISPLAY_CHARS))
		else $error("refresh position left the frame store");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(INIT_LEN))
		else $error("init step ran past the command list");

endmodule

FILE: hw/rtl/char_lcd_refresh_sequencer.sv
// Refresh sequencer for a 4x20 character display.
// Channels: item (valid/ready, item_t) carries ticks, store writes, init and
// command requests; result (valid/ready, result_t) gives one beat per tick
// item and nothing for the other opcodes; cfg (valid/ready, index + data)
// writes short_reload (index 0) and long_reload (index 1), always ready.
// Path: an accepted tick is written into the front queue, then popped into the
// result register, which drives its result beat.
// Throughput: one item per cycle; the front queue takes items while the back
// end runs, and the back end advances one queued item per cycle through its
// single store read port whenever the result register is empty or being taken.
// Store writes and other non-tick items leave the result channel untouched.
// Reset: sequencer idle, reloads 243 and 48, frame store reads as all zero at
// once (per-cell written flags), no clearing pass.
// Receiver stall: the result beat holds; the back end stops and the queue
// fills, after which item_ready drops until beats are taken again.
// Depends on crs_pkg, crs_front, crs_back.
module char_lcd_refresh_sequencer #(
	parameter int QUEUE_DEPTH = crs_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  crs_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output crs_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);
	import crs_pkg::*;

	logic    head_valid;
	entry_t  head;
	logic    pop;
	cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.we    = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	crs_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	crs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: tb/tb_char_lcd_refresh_sequencer.sv
// Self-checking testbench for char_lcd_refresh_sequencer: directed and random items,
// reload register changes between phases, scoreboard with its own refresh predictor.
// Depends on crs_pkg and the char_lcd_refresh_sequencer RTL.
`timescale 1ns / 1ps

module tb_char_lcd_refresh_sequencer;
	import crs_pkg::*;

	localparam int ITEM_TARGET   = 800;
	localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
	localparam int CYCLE_LIMIT   = 400000;

	class lcd_refresh_tracker;
		bit [7:0]    frame[DISPLAY_CHARS];
		bit [7:0]    boot_seq[INIT_LEN];
		bit [7:0]    line_addr_cmd[4];
		bit [6:0]    refresh_pos;
		mode_t       mode;
		bit [7:0]    queued_cmd;
		bit [2:0]    boot_idx;
		bit [7:0]    short_rl;
		bit [7:0]    long_rl;
		result_t     expected_beats[$];
		int          errors;

		function new();
			boot_seq = '{CMD_FUNC_SET, CMD_DISP_ON, CMD_CLEAR, CMD_LINE0, CMD_HOME};
			line_addr_cmd = '{CMD_LINE0, CMD_LINE1, CMD_LINE2, CMD_LINE3};
			foreach (frame[i]) frame[i] = 8'h00;
			refresh_pos = '0;
			mode = MODE_IDLE;
			queued_cmd = 8'h00;
			boot_idx = '0;
			short_rl = SHORT_RELOAD_RST;
			long_rl = LONG_RELOAD_RST;
			errors = 0;
		endfunction

		function void set_reload(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == CFG_SHORT_RELOAD) short_rl = val;
			else long_rl = val;
		endfunction

		function bit [7:0] reload_after(bit [7:0] c);
			return (c == CMD_CLEAR) ? long_rl : short_rl;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// accepted item: update the shadow state, queue the beat a tick produces
		function void note_item(item_t it);
			result_t r;
			r = '0;
			case (op_t'(it.opcode))
				OP_WRITE: begin
					if (it.char_address < DISPLAY_CHARS) frame[it.char_address] = it.char_code;
				end
				OP_INIT: begin
					boot_idx = '0;
					mode = MODE_INIT;
				end
				OP_CMD: begin
					queued_cmd = it.command_byte;
					mode = MODE_CMD;
				end
				default: begin
					case (mode)
						MODE_DATA: begin
							r.write_valid = 1'b1;
							r.register_select = 1'b1;
							r.bus_data = (refresh_pos < DISPLAY_CHARS) ? frame[refresh_pos] : 8'h00;
							r.timer_reload = short_rl;
							refresh_pos = (refresh_pos < DISPLAY_CHARS - 1) ? refresh_pos + 7'd1 : 7'd0;
							// line start: set-address command goes out before the next cell
							if (refresh_pos % LINE_CHARS == 0) begin
								queued_cmd = line_addr_cmd[refresh_pos / LINE_CHARS];
								mode = MODE_CMD;
							end
						end
						MODE_CMD: begin
							r.write_valid = 1'b1;
							r.bus_data = queued_cmd;
							r.timer_reload = reload_after(queued_cmd);
							mode = MODE_DATA;
						end
						MODE_INIT: begin
							if (boot_idx < INIT_LEN) begin
								r.write_valid = 1'b1;
								r.bus_data = boot_seq[boot_idx];
								r.timer_reload = reload_after(boot_seq[boot_idx]);
								boot_idx = boot_idx + 3'd1;
							end else begin
								// end of the boot list: quiet tick, then stream from cell 0
								r.timer_reload = short_rl;
								mode = MODE_DATA;
								boot_idx = '0;
								refresh_pos = '0;
							end
						end
						default: ;
					endcase
					expected_beats.push_back(r);
				end
			endcase
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			if (got.write_valid !== want.write_valid) begin
				$error("write_valid: expected %0d, got %0d", want.write_valid, got.write_valid);
				errors++;
			end
			if (got.register_select !== want.register_select) begin
				$error("register_select: expected %0d, got %0d",
					want.register_select, got.register_select);
				errors++;
			end
			if (got.bus_data !== want.bus_data) begin
				$error("bus_data: expected 0x%02h, got 0x%02h", want.bus_data, got.bus_data);
				errors++;
			end
			if (got.timer_reload !== want.timer_reload) begin
				$error("timer_reload: expected %0d, got %0d", want.timer_reload, got.timer_reload);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	lcd_refresh_tracker sb;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int items_sent = 0;

	char_lcd_refresh_sequencer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// result side: check taken beats, ready follows a changing stall pattern
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_beat(result);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 150);
		end
		rx_left--;
		case (rx_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= (rx_left % 4 == 0);
			default: result_ready <= (rx_left % 13 == 0);
		endcase
	end

	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
	endtask

	task automatic send_op(input op_t op, input logic [6:0] addr, input logic [7:0] code,
			input logic [7:0] cmd);
		item_t it;
		it.opcode = op;
		it.char_address = addr;
		it.char_code = code;
		it.command_byte = cmd;
		send_item(it);
	endtask

	// random item of a given operation; unused fields carry random content
	task automatic send_random(input op_t op, input bit mostly_in_range);
		logic [6:0] addr;
		logic [7:0] cmd;
		addr = (mostly_in_range && $urandom_range(0, 9) != 0) ? 7'($urandom_range(0, 79))
			: 7'($urandom_range(0, 127));
		cmd = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : 8'($urandom);
		send_op(op, addr, 8'($urandom), cmd);
		if (!(op == OP_WRITE && addr >= DISPLAY_CHARS)) items_sent++;
	endtask

	// hold the sender until every expected beat is back and the queue has emptied
	task automatic drain();
		item_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reload(idx, val);
	endtask

	initial begin
		int phase;
		int len;
		int pick;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, store extremes, clear timing, boot list, overrides
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_WRITE, 7'd0, 8'hFF, 8'h00);
		send_op(OP_WRITE, 7'd79, 8'h5A, 8'h00);
		send_op(OP_WRITE, 7'd80, 8'h11, 8'h00);
		send_op(OP_WRITE, 7'd127, 8'hEE, 8'hFF);
		send_op(OP_CMD, 7'd0, 8'h00, CMD_CLEAR);
		send_op(OP_TICK, 7'd127, 8'hFF, 8'hFF);
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_CMD, 7'd0, 8'h00, 8'h00);
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_INIT, 7'd0, 8'h00, 8'h00);
		repeat (7) send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_CMD, 7'd0, 8'h00, 8'hFF);
		send_op(OP_INIT, 7'd0, 8'h00, 8'h00);
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_CMD, 7'd0, 8'h00, CMD_CLEAR);
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);
		send_op(OP_TICK, 7'd0, 8'h00, 8'h00);

		for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
			drain();
			if (phase == 0) begin
				write_reg(CFG_SHORT_RELOAD, 8'd0);
				write_reg(CFG_LONG_RELOAD, 8'd255);
			end else if (phase == 1) begin
				write_reg(CFG_SHORT_RELOAD, 8'd255);
				write_reg(CFG_LONG_RELOAD, 8'd0);
			end else begin
				if ($urandom_range(0, 3) != 0) write_reg(CFG_SHORT_RELOAD, 8'($urandom));
				write_reg(CFG_LONG_RELOAD, 8'($urandom));
			end
			cfg_valid <= 1'b0;

			// stream phases run long enough to wrap the whole frame
			if (phase % 3 != 1) send_random(OP_INIT, 1'b1);
			len = (phase % 3 == 1) ? $urandom_range(60, 120) : $urandom_range(150, 260);
			repeat (len) begin
				pick = $urandom_range(0, 99);
				case (phase % 3)
					0: send_random((pick < 65) ? OP_TICK : OP_WRITE, 1'b1);
					1: send_random(op_t'($urandom_range(0, 3)), 1'b0);
					default: send_random((pick < 60) ? OP_TICK : (pick < 90) ? OP_WRITE
						: (pick < 97) ? OP_CMD : OP_INIT, 1'b1);
				endcase
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: char_lcd_refresh_sequencer.f
hw/rtl/crs_pkg.sv
hw/rtl/crs_front.sv
hw/rtl/crs_back.sv
hw/rtl/char_lcd_refresh_sequencer.sv
tb/tb_char_lcd_refresh_sequencer.sv
